// ----- rtl/rbmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rbmc_pkg: band and mode classifier shared definitions
// Band and region tables, mode codes and the result record that the lookup
// logic hands to the top level.
// ----------------------------------------------------------------------------
package rbmc_pkg;

	localparam int FREQ_W      = 31;
	localparam int INDEX_W     = 4;
	localparam int MODE_W      = 4;
	localparam int ROM_BANDS   = 12;
	localparam int ROM_REGIONS = 43;

	typedef logic [FREQ_W-1:0]  freq_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [MODE_W-1:0]  mode_t;

	// Starting distance of the nearest-edge search.
	localparam logic [31:0] NEAR_START = 32'd999999999;

	localparam mode_t MODE_CW_LOWER   = 4'd0;
	localparam mode_t MODE_CW_UPPER   = 4'd1;
	localparam mode_t MODE_LSB        = 4'd2;
	localparam mode_t MODE_USB        = 4'd3;
	localparam mode_t MODE_DIGI_UPPER = 4'd4;
	localparam mode_t MODE_NFM        = 4'd5;

	typedef struct packed {
		logic   found;
		index_t index;
		mode_t  mode;
	} result_t;

	localparam freq_t BAND_LO [ROM_BANDS] = '{
		31'd135700,   31'd1810000,  31'd3500000,  31'd5330500,
		31'd7000000,  31'd10100000, 31'd14000000, 31'd18068000,
		31'd21000000, 31'd24890000, 31'd28000000, 31'd50000000
	};

	localparam freq_t BAND_HI [ROM_BANDS] = '{
		31'd137800,   31'd2000000,  31'd3800000,  31'd5403500,
		31'd7200000,  31'd10150000, 31'd14350000, 31'd18168000,
		31'd21450000, 31'd24990000, 31'd29700000, 31'd54000000
	};

	localparam freq_t REG_LO [ROM_REGIONS] = '{
		31'd135700,
		31'd1810000,  31'd1838000,  31'd1843000,
		31'd3500000,  31'd3570000,  31'd3600000,
		31'd5330500,
		31'd7000000,  31'd7040000,  31'd7060000,  31'd7074000,  31'd7080000,
		31'd10100000, 31'd10130000,
		31'd14000000, 31'd14070000, 31'd14112000,
		31'd18068000, 31'd18095000, 31'd18120000,
		31'd21000000, 31'd21070000, 31'd21149000,
		31'd24890000, 31'd24915000, 31'd24940000,
		31'd28000000, 31'd28070000, 31'd28190000, 31'd28300000, 31'd28320000,
		31'd29100000, 31'd29200000, 31'd29300000, 31'd29520000,
		31'd50000000, 31'd50100000, 31'd50300000, 31'd50350000, 31'd50600000,
		31'd51000000, 31'd51100000
	};

	localparam freq_t REG_HI [ROM_REGIONS] = '{
		31'd137800,
		31'd1838000,  31'd1843000,  31'd2000000,
		31'd3570000,  31'd3600000,  31'd3800000,
		31'd5403500,
		31'd7040000,  31'd7060000,  31'd7074000,  31'd7080000,  31'd7200000,
		31'd10130000, 31'd10150000,
		31'd14070000, 31'd14112000, 31'd14350000,
		31'd18095000, 31'd18120000, 31'd18168000,
		31'd21070000, 31'd21149000, 31'd21450000,
		31'd24915000, 31'd24940000, 31'd24990000,
		31'd28070000, 31'd28190000, 31'd28300000, 31'd28320000, 31'd29100000,
		31'd29200000, 31'd29300000, 31'd29520000, 31'd29700000,
		31'd50100000, 31'd50300000, 31'd50350000, 31'd50600000, 31'd51000000,
		31'd51100000, 31'd54000000
	};

	localparam mode_t REG_MODE [ROM_REGIONS] = '{
		MODE_CW_LOWER,
		MODE_CW_LOWER, MODE_DIGI_UPPER, MODE_LSB,
		MODE_CW_LOWER, MODE_DIGI_UPPER, MODE_LSB,
		MODE_USB,
		MODE_CW_LOWER, MODE_DIGI_UPPER, MODE_LSB, MODE_DIGI_UPPER, MODE_LSB,
		MODE_CW_UPPER, MODE_DIGI_UPPER,
		MODE_CW_UPPER, MODE_DIGI_UPPER, MODE_USB,
		MODE_CW_UPPER, MODE_DIGI_UPPER, MODE_USB,
		MODE_CW_UPPER, MODE_DIGI_UPPER, MODE_USB,
		MODE_CW_UPPER, MODE_DIGI_UPPER, MODE_USB,
		MODE_CW_UPPER, MODE_DIGI_UPPER, MODE_CW_UPPER, MODE_DIGI_UPPER, MODE_USB,
		MODE_NFM, MODE_DIGI_UPPER, MODE_USB, MODE_NFM,
		MODE_CW_UPPER, MODE_USB, MODE_DIGI_UPPER, MODE_USB, MODE_DIGI_UPPER,
		MODE_USB, MODE_NFM
	};

	// Band that owns each region.
	localparam index_t REG_BAND [ROM_REGIONS] = '{
		4'd0,
		4'd1, 4'd1, 4'd1,
		4'd2, 4'd2, 4'd2,
		4'd3,
		4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
		4'd5, 4'd5,
		4'd6, 4'd6, 4'd6,
		4'd7, 4'd7, 4'd7,
		4'd8, 4'd8, 4'd8,
		4'd9, 4'd9, 4'd9,
		4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
		4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11
	};

	// Last frequency of the gap after band b that is at least as close to the
	// end of band b as to the start of band b+1 (ties go to the lower band).
	function automatic freq_t gap_split(input int b);
		logic [31:0] sum;
		sum = {1'b0, BAND_HI[b]} + {1'b0, BAND_LO[b+1]};
		return sum[31:1];
	endfunction

	// First frequency above band b whose distance to its end edge is no longer
	// below the starting distance of the search.
	function automatic freq_t far_limit(input int b);
		logic [31:0] sum;
		sum = {1'b0, BAND_HI[b]} + NEAR_START;
		return sum[FREQ_W-1:0];
	endfunction

endpackage

// ----- rtl/radio_band_and_mode_classifier_core.sv -----
// ----------------------------------------------------------------------------
// radio_band_and_mode_classifier_core: tuning frequency classifier
// Reports the amateur band and the demodulation mode for a frequency.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries frequency, want_nearest and
// current_mode. The output channel (out_valid, out_stall) carries band_found,
// band_index and mode_code, one result transaction per input transaction,
// in order.
// Each transaction is captured in an input register, classified by parallel
// constant compares, and held in a result register: out_valid rises once the
// result register has taken the result, and one transaction is taken every
// cycle while in_stall is low.
// When the receiver stalls, the result register holds and the input register
// keeps filling; in_stall rises only once both registers are occupied and
// out_stall is high, so throughput recovers with no lost cycle.
// Reset clears both valid flags; no transaction is in flight afterwards and
// the block can take input as soon as reset is released.
// ----------------------------------------------------------------------------
module radio_band_and_mode_classifier_core #(
	parameter int BAND_COUNT = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [30:0]            frequency,
	input  logic                   want_nearest,
	input  logic [3:0]             current_mode,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   band_found,
	output logic [3:0]             band_index,
	output logic [3:0]             mode_code
);

	logic              valid_s1;
	rbmc_pkg::freq_t   freq_s1;
	logic              nearest_s1;
	rbmc_pkg::mode_t   mode_s1;
	logic              valid_s2;
	rbmc_pkg::result_t result_s2;
	rbmc_pkg::result_t lookup;
	logic              adv_s1;
	logic              adv_s2;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			freq_s1    <= frequency;
			nearest_s1 <= want_nearest;
			mode_s1    <= current_mode;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= lookup;
		end
	end

	rbmc_lookup #(
		.BAND_COUNT(BAND_COUNT)
	) u_lookup (
		.frequency    (freq_s1),
		.want_nearest (nearest_s1),
		.current_mode (mode_s1),
		.result       (lookup)
	);

	assign out_valid  = valid_s2;
	assign band_found = result_s2.found;
	assign band_index = result_s2.index;
	assign mode_code  = result_s2.mode;

endmodule

// ----- rtl/rbmc_lookup.sv -----
// ----------------------------------------------------------------------------
// rbmc_lookup: band, nearest band and mode lookup
// Compares one frequency against every band and region edge in parallel.
// Bands and regions are sorted and disjoint, so at most one of each matches
// and the nearest edge outside all bands is found from the gap it lies in.
// ----------------------------------------------------------------------------
module rbmc_lookup #(
	parameter int BAND_COUNT = 12
) (
	input  rbmc_pkg::freq_t   frequency,
	input  logic              want_nearest,
	input  rbmc_pkg::mode_t   current_mode,
	output rbmc_pkg::result_t result
);

	localparam int NB = (BAND_COUNT > rbmc_pkg::ROM_BANDS) ? rbmc_pkg::ROM_BANDS
		: BAND_COUNT;

	logic             held;
	rbmc_pkg::index_t held_idx;
	rbmc_pkg::index_t near_idx;
	rbmc_pkg::mode_t  reg_mode;

	always_comb begin
		held     = 1'b0;
		held_idx = '0;
		for (int b = 0; b < rbmc_pkg::ROM_BANDS; b++) begin
			if (b < NB && frequency >= rbmc_pkg::BAND_LO[b]
					&& frequency <= rbmc_pkg::BAND_HI[b]) begin
				held     = 1'b1;
				held_idx = 4'(b);
			end
		end
	end

	// A region match implies its band holds the frequency, as regions tile
	// their band; the band end itself falls in no region.
	always_comb begin
		reg_mode = current_mode;
		for (int r = 0; r < rbmc_pkg::ROM_REGIONS; r++) begin
			if (int'(rbmc_pkg::REG_BAND[r]) < NB && frequency >= rbmc_pkg::REG_LO[r]
					&& frequency < rbmc_pkg::REG_HI[r]) begin
				reg_mode = rbmc_pkg::REG_MODE[r];
			end
		end
	end

	// Below the first band the nearest edge is its start. In a gap the
	// choice is between the two facing edges. Above the last active band its
	// end wins only while closer than the starting distance.
	always_comb begin
		near_idx = '0;
		for (int b = 0; b < rbmc_pkg::ROM_BANDS - 1; b++) begin
			if (b + 1 < NB && frequency > rbmc_pkg::BAND_HI[b]
					&& frequency < rbmc_pkg::BAND_LO[b+1]) begin
				near_idx = (frequency <= rbmc_pkg::gap_split(b)) ? 4'(b) : 4'(b + 1);
			end
		end
		if (frequency > rbmc_pkg::BAND_HI[NB-1]
				&& frequency < rbmc_pkg::far_limit(NB - 1)) begin
			near_idx = 4'(NB - 1);
		end
	end

	always_comb begin
		result.found = held | want_nearest;
		result.index = held ? held_idx : (want_nearest ? near_idx : '0);
		result.mode  = reg_mode;
	end

endmodule

// ----- rtl/rbmc_checker.sv -----
// ----------------------------------------------------------------------------
// rbmc_checker: port-level checks for the classifier core
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module rbmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       band_found,
	input logic [3:0] band_index,
	input logic [3:0] mode_code
);

	// A stalled result stays put until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(band_found)
			&& $stable(band_index) && $stable(mode_code))
		else $error("stalled result changed");

	// Back pressure only reaches the input when a result is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side is free");

	// With the output free, the input is held off in the next cycle only if out_valid was high as well or is high by then.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> !in_stall || $past(out_valid) || out_valid)
		else $error("input stalled without a pending result");

	// Without a band the index reads zero, and indexes stay within the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (band_found || band_index == 4'd0) && band_index <= 4'd11)
		else $error("band index inconsistent with band_found");

endmodule

bind radio_band_and_mode_classifier_core rbmc_checker u_rbmc_checker (.*);
